FILE: src/fnpd_pkg.sv
`timescale 1ns / 1ps

package fnpd_pkg;

   localparam int DEF_MAX_COLS    = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_SAMPLE_BITS = 16;

   // size registers, position fields, counter compare width
   localparam int CFG_W     = 11;
   localparam int POS_W     = 10;
   localparam int CMP_W     = 14;
   localparam int REG_IDX_W = 1;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FRAME_ROWS = 1'b0,
      REG_FRAME_COLS = 1'b1
   } reg_idx_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   // per-word command from the counters to the line buffer stage
   typedef struct packed {
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
      logic emit;
      logic wr_mid;
      logic frame_end;
   } cmd_type;

   // 0 acts as 1, anything above the maximum acts as the maximum
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > maxv) begin
         r = CFG_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: src/four_neighbour_peak_detect.sv
// Four-neighbour peak detector over a raster-order frame of signed samples.
// req_ channel: one word per sample, tuser = 0 (sample in tdata), row by row.
// After the last row the host sends one drain word (tuser = 1) per column;
// drain words outside the final row and samples while draining are dropped.
// rsp_ channel: one word per decided element. A pixel is decided when the
// sample below it arrives, so results trail the input by one row; the final
// row comes out on the drain words. tlast marks the frame's last element.
// csr_ port: register 0 = frame rows, 1 = frame columns (0 acts as 1, values
// above the maximum act as the maximum). Write only while the block is idle.
// Throughput: one word per cycle on both sides while rsp_tready is high. A
// result word passes through the decision stage, which holds the registered
// read of the two line buffers, and then the output register.
// Stalls: the output register holds while rsp_tready is low; one more word
// sits in the decision stage, after which req_tready drops.
// Reset clears counters, size registers (both to 1) and all valid flags. The
// line buffers are not cleared; each entry is written before its value is used.
`timescale 1ns / 1ps

module four_neighbour_peak_detect
   import fnpd_pkg::*;
#(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int OUT_TDATA_W = ((2 * POS_W + SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_TDATA_W-1:0]  req_tdata,   // sample
   input  logic                   req_tuser,   // mode: 0 sample, 1 drain
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata,   // pos_row, pos_col, value
   output logic                   rsp_tuser,   // is_peak
   output logic                   rsp_tlast,   // frame_end
   // register writes
   input  logic                   csr_wr_en,
   input  logic [REG_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic                          acc, stage_free, out_free;
   cmd_type                       cmd;
   logic [COL_W-1:0]              col;
   logic [POS_W-1:0]              row_pos;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          res_valid, res_peak, res_last;
   logic [POS_W-1:0]              res_row, res_col;
   logic signed [SAMPLE_BITS-1:0] res_value;

   assign sample = req_tdata[SAMPLE_BITS-1:0];

   // frame counters, size registers, word decode
   fnpd_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_mode   (mode_type'(req_tuser)),
      .stage_free (stage_free),
      .req_ready  (req_tready),
      .acc        (acc),
      .cmd        (cmd),
      .col        (col),
      .row_pos    (row_pos)
   );

   // line buffers, read-modify-write with forwarding, neighbour compare
   fnpd_core #(
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .cmd        (cmd),
      .col        (col),
      .row_pos    (row_pos),
      .sample     (sample),
      .out_free   (out_free),
      .stage_free (stage_free),
      .res_valid  (res_valid),
      .res_row    (res_row),
      .res_col    (res_col),
      .res_value  (res_value),
      .res_peak   (res_peak),
      .res_last   (res_last)
   );

   // output register
   fnpd_out #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .row        (res_row),
      .col        (res_col),
      .value      (res_value),
      .peak       (res_peak),
      .last       (res_last),
      .rsp_tready (rsp_tready),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/fnpd_ctrl.sv
`timescale 1ns / 1ps

module fnpd_ctrl
   import fnpd_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  mode_type             req_mode,
   input  logic                 stage_free,
   output logic                 req_ready,
   output logic                 acc,
   output cmd_type              cmd,
   output logic [COL_W-1:0]     col,
   output logic [POS_W-1:0]     row_pos
);

   logic [CFG_W-1:0] frame_rows_ff, frame_rows_in;
   logic [CFG_W-1:0] frame_cols_ff, frame_cols_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             drain_ff, drain_in;
   logic [CFG_W-1:0] rows_eff, cols_eff;
   logic             last_col, last_row, is_pix, act;

   assign rows_eff = clamp_size(frame_rows_ff, MAX_ROWS);
   assign cols_eff = clamp_size(frame_cols_ff, MAX_COLS);
   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(cols_eff);
   assign last_row = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(rows_eff);

   assign is_pix    = (req_mode == MODE_PIXEL);
   assign act       = is_pix ? !drain_ff : drain_ff;
   assign req_ready = !reset && stage_free;
   assign acc       = req_valid && req_ready && act;
   assign col       = col_ff;

   always_comb begin
      cmd.has_up    = is_pix ? (CMP_W'(row_ff) > CMP_W'(1)) : (row_ff != '0);
      cmd.has_down  = is_pix;
      cmd.has_left  = (col_ff != '0);
      cmd.has_right = !last_col;
      cmd.emit      = is_pix ? (row_ff != '0) : 1'b1;
      cmd.wr_mid    = is_pix;
      cmd.frame_end = !is_pix && last_col;
      row_pos       = is_pix ? POS_W'(row_ff - ROW_W'(1)) : POS_W'(row_ff);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (acc) begin
         if (last_col) begin
            col_in = '0;
            if (is_pix) begin
               if (last_row) begin
                  drain_in = 1'b1;
               end else begin
                  row_in = ROW_W'(row_ff + ROW_W'(1));
               end
            end else begin
               row_in   = '0;
               drain_in = 1'b0;
            end
         end else begin
            col_in = COL_W'(col_ff + COL_W'(1));
         end
      end
   end

   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_FRAME_ROWS: frame_rows_in = csr_wdata;
            REG_FRAME_COLS: frame_cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= CFG_W'(1);
         frame_cols_ff <= CFG_W'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         drain_ff      <= 1'b0;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         drain_ff      <= drain_in;
      end
   end

endmodule

FILE: src/fnpd_core.sv
`timescale 1ns / 1ps

module fnpd_core
   import fnpd_pkg::*;
#(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc,
   input  cmd_type                       cmd,
   input  logic [COL_W-1:0]              col,
   input  logic [POS_W-1:0]              row_pos,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          out_free,
   output logic                          stage_free,
   output logic                          res_valid,
   output logic [POS_W-1:0]              res_row,
   output logic [POS_W-1:0]              res_col,
   output logic signed [SAMPLE_BITS-1:0] res_value,
   output logic                          res_peak,
   output logic                          res_last
);

   // line buffers: middle holds the row being decided, upper the row above it
   logic signed [SAMPLE_BITS-1:0] mid_buf_ff [MAX_COLS];
   logic signed [SAMPLE_BITS-1:0] up_buf_ff  [MAX_COLS];

   logic signed [SAMPLE_BITS-1:0] mid_q0_ff, mid_q1_ff, up_q_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_mid_ff, fwd_up_ff, left_ff;
   logic                          fwd_m0_ff, fwd_m1_ff, fwd_u_ff;

   logic                          b_valid_ff, b_valid_in;
   cmd_type                       b_cmd_ff;
   logic [COL_W-1:0]              b_col_ff;
   logic [POS_W-1:0]              b_row_ff;
   logic signed [SAMPLE_BITS-1:0] b_sample_ff;

   logic [COL_W-1:0]              col_nx;
   logic                          b_fire;
   logic signed [SAMPLE_BITS-1:0] cur, right, up;

   // right-hand neighbour address; wraps harmlessly on the last buffer column
   assign col_nx = (int'(col) == MAX_COLS - 1) ? '0 : COL_W'(col + COL_W'(1));

   assign b_fire     = b_valid_ff && (!b_cmd_ff.emit || out_free);
   assign stage_free = !b_valid_ff || b_fire;

   // a write retiring on the read edge is forwarded (frames one or two wide)
   assign cur   = fwd_m0_ff ? fwd_mid_ff : mid_q0_ff;
   assign right = fwd_m1_ff ? fwd_mid_ff : mid_q1_ff;
   assign up    = fwd_u_ff  ? fwd_up_ff  : up_q_ff;

   always_comb begin
      res_peak = 1'b1;
      if (b_cmd_ff.has_up && (cur <= up)) begin
         res_peak = 1'b0;
      end
      if (b_cmd_ff.has_down && (cur <= b_sample_ff)) begin
         res_peak = 1'b0;
      end
      if (b_cmd_ff.has_left && (cur <= left_ff)) begin
         res_peak = 1'b0;
      end
      if (b_cmd_ff.has_right && (cur <= right)) begin
         res_peak = 1'b0;
      end
   end

   assign res_valid = b_fire && b_cmd_ff.emit;
   assign res_row   = b_row_ff;
   assign res_col   = POS_W'(b_col_ff);
   assign res_value = cur;
   assign res_last  = b_cmd_ff.frame_end;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (acc) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         mid_q0_ff <= mid_buf_ff[col];
         mid_q1_ff <= mid_buf_ff[col_nx];
         up_q_ff   <= up_buf_ff[col];
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         up_buf_ff[b_col_ff] <= cur;
         if (b_cmd_ff.wr_mid) begin
            mid_buf_ff[b_col_ff] <= b_sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_cmd_ff    <= cmd;
         b_col_ff    <= col;
         b_row_ff    <= row_pos;
         b_sample_ff <= sample;
         fwd_m0_ff   <= b_fire && b_cmd_ff.wr_mid && (b_col_ff == col);
         fwd_m1_ff   <= b_fire && b_cmd_ff.wr_mid && (b_col_ff == col_nx);
         fwd_u_ff    <= b_fire && (b_col_ff == col);
         fwd_mid_ff  <= b_sample_ff;
         fwd_up_ff   <= cur;
      end
      if (b_fire) begin
         left_ff <= cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

endmodule

FILE: src/fnpd_out.sv
`timescale 1ns / 1ps

module fnpd_out
   import fnpd_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int OUT_W = ((2 * POS_W + SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [POS_W-1:0]              row,
   input  logic [POS_W-1:0]              col,
   input  logic signed [SAMPLE_BITS-1:0] value,
   input  logic                          peak,
   input  logic                          last,
   input  logic                          rsp_tready,
   output logic                          out_free,
   output logic                          rsp_tvalid,
   output logic [OUT_W-1:0]              rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   logic                          valid_ff, valid_in;
   logic [POS_W-1:0]              row_ff, col_ff;
   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic                          peak_ff, last_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff   <= row;
         col_ff   <= col;
         value_ff <= value;
         peak_ff  <= peak;
         last_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = OUT_W'({value_ff, col_ff, row_ff});
   assign rsp_tuser  = peak_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: src/fnpd_checker.sv
`timescale 1ns / 1ps

module fnpd_checker #(
   parameter int DATA_W = 40
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser,
   input logic              rsp_tlast
);

   // no result word survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))
      else $error("stalled result word changed");

   // input back-pressure only when the output side is blocked
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // a fresh result word has an accepted request word behind it, through the decision stage and output register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result word with no request behind it");

endmodule

bind four_neighbour_peak_detect fnpd_checker #(
   .DATA_W (OUT_TDATA_W)
) u_fnpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
